// ----- sv/upc_pkg.sv -----
// upc_pkg: shared types, character constants and helper functions
// for the url percent codec; no dependencies
`default_nettype none

package upc_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// decoder escape tracking
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	// up to three output bytes produced by one input item
	typedef struct packed {
		logic [1:0]      cnt;
		logic            last;
		logic [2:0][7:0] bytes;
	} bundle_t;

	// {valid, value}
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(b - 8'h37)};
		end else if (b inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(b - 8'h57)};
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'd0, n};
		end else begin
			r = 8'h57 + {4'd0, n};
		end
		return r;
	endfunction

	function automatic logic passes_plain(input logic [7:0] b);
		return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h21, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h5F});
	endfunction

endpackage

`default_nettype wire

// ----- sv/upc_ifs.sv -----
// upc_ifs: valid/ready channel interfaces of the url percent codec
// (text input, coded output, mode write); no dependencies
`default_nettype none

interface upc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface upc_cfg_if;
	logic valid;
	logic ready;
	logic mode;

	modport source (output valid, output mode, input ready);
	modport sink   (input valid, input mode, output ready);
endinterface

`default_nettype wire

// ----- sv/upc_front.sv -----
// upc_front: accepts text bytes, holds mode and escape state, and turns
// each item into a bundle of up to three bytes; uses upc_pkg, upc_ifs
`default_nettype none

module upc_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	upc_in_if.sink         raw,
	upc_cfg_if.sink        cfg,
	input  wire logic      q_full,
	output logic           push,
	output upc_pkg::bundle_t push_data
);

	logic       mode_q;
	logic [1:0] phase_q;
	logic [7:0] held_q;

	logic            acc;
	logic [7:0]      b;
	logic            last;
	logic [4:0]      hv_in;
	logic [4:0]      hv_held;
	logic            ord_n;
	logic [7:0]      ord_b;
	logic [1:0]      ord_ph;
	logic [1:0]      pre_n;
	logic            use_ord;
	logic [1:0]      cnt;
	logic [2:0][7:0] byt;
	logic [1:0]      ph_nxt;
	logic            held_wr;

	assign raw.ready = !q_full;
	assign cfg.ready = 1'b1;
	assign acc       = raw.valid && raw.ready;
	assign b         = raw.in_byte;
	assign last      = raw.in_last;
	assign hv_in     = upc_pkg::hex_value(b);
	assign hv_held   = upc_pkg::hex_value(held_q);

	// byte taken as plain text (no escape open)
	always_comb begin
		ord_n  = 1'b1;
		ord_b  = b;
		ord_ph = upc_pkg::PH_IDLE;
		if (b == upc_pkg::CH_PERCENT) begin
			if (!last) begin
				ord_n  = 1'b0;
				ord_ph = upc_pkg::PH_PCT;
			end
		end else if (b == upc_pkg::CH_PLUS) begin
			ord_b = upc_pkg::CH_SPACE;
		end
	end

	always_comb begin
		cnt     = 2'd0;
		byt     = '0;
		ph_nxt  = phase_q;
		held_wr = 1'b0;
		pre_n   = 2'd0;
		use_ord = 1'b0;
		if (!mode_q) begin
			if (b == upc_pkg::CH_SPACE) begin
				cnt    = 2'd1;
				byt[0] = upc_pkg::CH_PLUS;
			end else if (upc_pkg::passes_plain(b)) begin
				cnt    = 2'd1;
				byt[0] = b;
			end else begin
				cnt    = 2'd3;
				byt[0] = upc_pkg::CH_PERCENT;
				byt[1] = upc_pkg::hex_digit(b[7:4]);
				byt[2] = upc_pkg::hex_digit(b[3:0]);
			end
		end else begin
			case (phase_q)
				upc_pkg::PH_PCT: begin
					if (hv_in[4]) begin
						if (last) begin
							cnt    = 2'd2;
							byt[0] = upc_pkg::CH_PERCENT;
							byt[1] = b;
							ph_nxt = upc_pkg::PH_IDLE;
						end else begin
							held_wr = 1'b1;
							ph_nxt  = upc_pkg::PH_DIGIT;
						end
					end else begin
						byt[0]  = upc_pkg::CH_PERCENT;
						pre_n   = 2'd1;
						use_ord = 1'b1;
					end
				end
				upc_pkg::PH_DIGIT: begin
					if (hv_in[4] && hv_held[4]) begin
						cnt    = 2'd1;
						byt[0] = {hv_held[3:0], hv_in[3:0]};
						ph_nxt = upc_pkg::PH_IDLE;
					end else begin
						// broken escape: flush '%' and the held digit first
						byt[0]  = upc_pkg::CH_PERCENT;
						byt[1]  = held_q;
						pre_n   = 2'd2;
						use_ord = 1'b1;
					end
				end
				default: begin
					use_ord = 1'b1;
				end
			endcase
			if (use_ord) begin
				ph_nxt = ord_ph;
				cnt    = pre_n + {1'b0, ord_n};
				if (ord_n) begin
					case (pre_n)
						2'd0:    byt[0] = ord_b;
						2'd1:    byt[1] = ord_b;
						default: byt[2] = ord_b;
					endcase
				end
			end
		end
	end

	assign push      = acc && (cnt != 2'd0);
	assign push_data = {cnt, last, byt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			phase_q <= upc_pkg::PH_IDLE;
		end else if (cfg.valid) begin
			mode_q  <= cfg.mode;
			phase_q <= upc_pkg::PH_IDLE;
		end else if (acc) begin
			phase_q <= ph_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && held_wr) begin
			held_q <= b;
		end
	end

endmodule

`default_nettype wire

// ----- sv/upc_queue.sv -----
// upc_queue: short fifo of byte bundles between front and back
// uses upc_pkg
`default_nettype none

module upc_queue #(
	parameter int Depth = upc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire upc_pkg::bundle_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output upc_pkg::bundle_t      head_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	upc_pkg::bundle_t mem_q [Depth];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full       = (cnt_q == CW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- sv/upc_back.sv -----
// upc_back: drains queued bundles one byte per cycle, while coded takes
// its bytes, into the output register; uses upc_pkg, upc_ifs
`default_nettype none

module upc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire upc_pkg::bundle_t head_data,
	output logic                  pop,
	upc_out_if.source             coded
);

	logic [1:0] idx_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;

	logic       load;
	logic       is_end;
	logic [7:0] sel_b;

	assign is_end = (idx_q == head_data.cnt - 2'd1);
	assign load   = head_valid && (!ov_q || coded.ready);
	assign pop    = load && is_end;

	always_comb begin
		case (idx_q)
			2'd0:    sel_b = head_data.bytes[0];
			2'd1:    sel_b = head_data.bytes[1];
			default: sel_b = head_data.bytes[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= is_end ? 2'd0 : idx_q + 2'd1;
			end else if (coded.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ob_q <= sel_b;
			ol_q <= head_data.last && is_end;
		end
	end

	assign coded.valid    = ov_q;
	assign coded.out_byte = ob_q;
	assign coded.out_last = ol_q;

endmodule

`default_nettype wire

// ----- sv/url_percent_codec.sv -----
// url_percent_codec: streaming url form encoder / decoder, top level
// uses upc_pkg, upc_ifs, upc_front, upc_queue, upc_back
`default_nettype none

// Text bytes enter on raw, coded bytes leave on coded, and a write on cfg
// selects encode (mode 0) or decode (mode 1) and drops any pending escape.
// Each item is classified as it is accepted and queued as one to three
// output bytes (none while a decode escape is still open); the output
// register sends one byte per cycle while coded is ready. Plain text
// streams at one item per cycle while coded is ready; an item that yields
// two or three bytes occupies the single-byte output register for each in
// turn, which back-pressures raw once the bundle queue (QueueDepth entries)
// is full. The first byte of an item passes through the bundle queue and
// then the output register before it is valid on coded.
// Write cfg only while no item is in flight.
module url_percent_codec #(
	parameter int QueueDepth = upc_pkg::QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	upc_in_if.sink    raw,
	upc_cfg_if.sink   cfg,
	upc_out_if.source coded
);

	logic             push;
	logic             q_full;
	logic             pop;
	logic             head_valid;
	upc_pkg::bundle_t push_data;
	upc_pkg::bundle_t head_data;

	upc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	upc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	upc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.coded      (coded)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("bundle pushed into a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

	// the final byte of a string always flushes something
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		(raw.valid && raw.ready && raw.in_last) |-> push)
		else $error("last item produced no output bytes");

endmodule

`default_nettype wire
